FILE: rtl/d2s_pkg.sv
package d2s_pkg;
  localparam int unsigned DW = 64;
  localparam int unsigned SW = 32;
  localparam logic [10:0] EXP64_ALL = 11'h7ff;
  localparam logic [31:0] INF32_BITS = 32'h7f800000;
  localparam logic [31:0] QUIET32_BIT = 32'h00400000;
  localparam int NORMAL_SHIFT = 29;
  localparam int PIPE_STAGES = 3;

  typedef enum logic [1:0] {
    K_FINITE = 2'd0,
    K_INF    = 2'd1,
    K_NAN    = 2'd2,
    K_ZERO   = 2'd3
  } kind_t;
endpackage

FILE: rtl/d2s_if.sv
interface d2s_if #(parameter int unsigned W = d2s_pkg::DW);
  logic valid;
  logic ready;
  logic [W-1:0] data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

FILE: rtl/double_to_single_float_convert.sv
// An accepted input beat passes the stage 1, stage 2 and stage 3 registers to its output beat.
// Throughput: one beat per cycle; the three register stages share one
// stall enable, so a held output freezes the whole pipe without loss.
// Reset: synchronous active-low rst_n clears the stage valid bits only.
module double_to_single_float_convert (
  input  logic clk,
  input  logic rst_n,
  d2s_if.sink   in_ch,
  d2s_if.source out_ch
);
  import d2s_pkg::*;

  logic adv;
  assign adv = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = adv;

  // Stage 1: classify and select shift.
  logic        v1_r;
  logic        s1_r;
  kind_t       k1_r;
  logic        sub1_r;
  logic [5:0]  sh1_r;
  logic [52:0] m1_r;
  logic [7:0]  e1_r;
  logic [22:0] nf1_r;

  logic [10:0] bexp;
  logic [51:0] frac;
  logic signed [12:0] uexp;
  kind_t k_nxt;
  logic [5:0] sh_nxt;
  always_comb begin
    bexp = in_ch.data[62:52];
    frac = in_ch.data[51:0];
    uexp = $signed({2'b00, bexp}) - 13'sd1023;
    sh_nxt = 6'(NORMAL_SHIFT);
    if (bexp == EXP64_ALL) k_nxt = (frac == '0) ? K_INF : K_NAN;
    else if (bexp == '0) k_nxt = K_ZERO;
    else if (uexp > 13'sd127) k_nxt = K_INF;
    else if (uexp < -13'sd150) k_nxt = K_ZERO;
    else k_nxt = K_FINITE;
    if (uexp < -13'sd126) sh_nxt = 6'(-13'sd97 - uexp);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (adv) v1_r <= in_ch.valid;
    if (adv) begin
      s1_r <= in_ch.data[63];
      k1_r <= k_nxt;
      sub1_r <= uexp < -13'sd126;
      sh1_r <= sh_nxt;
      m1_r <= {1'b1, frac};
      e1_r <= 8'(uexp + 13'sd126);
      nf1_r <= frac[51:29];
    end
  end

  // Stage 2: shift and form the rounding terms.
  logic        v2_r, s2_r, sub2_r, inc2_r;
  kind_t       k2_r;
  logic [7:0]  e2_r;
  logic [22:0] nf2_r;
  logic [24:0] kept2_r;
  logic [52:0] rem, half;
  logic [24:0] kept_nxt;
  logic inc_nxt;
  always_comb begin
    kept_nxt = 25'(m1_r >> sh1_r);
    half = 53'(1) << (sh1_r - 6'd1);
    rem = m1_r & ((half << 1) - 53'd1);
    inc_nxt = (rem > half) || (rem == half && kept_nxt[0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (adv) v2_r <= v1_r;
    if (adv) begin
      s2_r <= s1_r; k2_r <= k1_r; sub2_r <= sub1_r; e2_r <= e1_r;
      nf2_r <= nf1_r; kept2_r <= kept_nxt; inc2_r <= inc_nxt;
    end
  end

  // Stage 3: round and assemble.
  logic [31:0] res;
  logic [31:0] kept_rnd;
  always_comb begin
    kept_rnd = 32'(kept2_r) + 32'(inc2_r);
    case (k2_r)
      K_INF:  res = {s2_r, 31'b0} | INF32_BITS;
      K_NAN:  res = {s2_r, 31'b0} | INF32_BITS | {9'b0, nf2_r} | QUIET32_BIT;
      K_ZERO: res = {s2_r, 31'b0};
      default: begin
        if (sub2_r) res = {s2_r, 31'b0} | kept_rnd;
        else res = {s2_r, 31'b0} | (({24'b0, e2_r} << 23) + kept_rnd);
      end
    endcase
  end

  logic        v3_r;
  logic [31:0] d3_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else if (adv) v3_r <= v2_r;
    if (adv) d3_r <= res;
  end

  assign out_ch.valid = v3_r;
  assign out_ch.data = d3_r;

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |=> $stable(d3_r) && $stable(v2_r))
    else $error("pipeline moved during stall");
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && adv) |=> out_ch.valid)
    else $error("beat lost between stage 2 and output");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_ch.valid |-> in_ch.ready)
    else $error("input stalled with empty output");
endmodule

FILE: tb/sv/double_to_single_float_convert_tb.sv
`timescale 1ns / 1ps

module double_to_single_float_convert_tb;
  import d2s_pkg::*;

  localparam int IDLE_PCT = 11;
  localparam int STALL_LIMIT = 2000;

  logic clk;
  logic rst_n;

  d2s_if #(.W(DW)) in_ch();
  d2s_if #(.W(SW)) out_ch();

  double_to_single_float_convert dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch.sink),
    .out_ch(out_ch.source)
  );

  logic [SW-1:0] single_q[$];
  int errors = 0;
  int idle_cycles = 0;
  bit no_idle = 0;
  bit hold_off = 0;
  bit done = 0;

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // Narrowing with round to nearest, ties to even.
  function automatic logic [SW-1:0] narrow_double(logic [DW-1:0] d);
    logic [31:0] sgn;
    logic [10:0] bexp;
    logic [51:0] frac;
    int uexp;
    int sh;
    logic [63:0] mant;
    logic [63:0] rem;
    logic [63:0] half;
    logic [31:0] kept;
    sgn = {d[63], 31'b0};
    bexp = d[62:52];
    frac = d[51:0];
    if (bexp == EXP64_ALL) begin
      if (frac == 0) return sgn | INF32_BITS;
      return sgn | INF32_BITS | 32'(frac >> NORMAL_SHIFT) | QUIET32_BIT;
    end
    if (bexp == 0) return sgn;
    uexp = int'(bexp) - 1023;
    if (uexp > 127) return sgn | INF32_BITS;
    if (uexp < -150) return sgn;
    mant = {12'd1, frac};
    sh = (uexp >= -126) ? NORMAL_SHIFT : (-97 - uexp);
    kept = 32'(mant >> sh);
    rem = mant & ((64'd1 << sh) - 64'd1);
    half = 64'd1 << (sh - 1);
    if (rem > half || (rem == half && kept[0])) kept = kept + 1;
    if (uexp < -126) return sgn | kept;
    return sgn | ((32'(uexp + 126) << 23) + kept);
  endfunction

  task automatic report_mismatch(input string what, input logic [SW-1:0] got,
                                 input logic [SW-1:0] want);
    $display("mismatch %s: got %08h expected %08h at %0t", what, got, want, $time);
    errors++;
  endtask

  task automatic send_double(input logic [DW-1:0] d);
    while (!no_idle && $urandom_range(99, 0) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= d;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    single_q.push_back(narrow_double(d));
  endtask

  task automatic drop_valid();
    in_ch.valid <= 1'b0;
  endtask

  function automatic logic [DW-1:0] make_double(bit s, logic [10:0] e, logic [51:0] f);
    return {s, e, f};
  endfunction

  function automatic logic [51:0] rand_frac();
    return 52'({$urandom(), $urandom()});
  endfunction

  task automatic wait_drained();
    drop_valid();
    while (single_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_special_values();
    send_double(64'h0000_0000_0000_0000);
    send_double(64'h8000_0000_0000_0000);
    send_double(64'h0000_0000_0000_0001);
    send_double(64'h800f_ffff_ffff_ffff);
    send_double(64'h7ff0_0000_0000_0000);
    send_double(64'hfff0_0000_0000_0000);
    send_double(64'h7ff0_0000_0000_0001);
    send_double(64'hfff8_0000_0000_0000);
    send_double(64'h7fff_ffff_ffff_ffff);
    send_double(64'h3ff0_0000_0000_0000);
    send_double(64'h47ef_ffff_e000_0000);
    send_double(64'h47ef_ffff_f000_0000);
    send_double(64'h47f0_0000_0000_0000);
    send_double(64'hc7ef_ffff_efff_ffff);
    send_double(64'h3690_0000_0000_0000);
    send_double(64'h3690_0000_0000_0001);
    send_double(64'h368f_ffff_ffff_ffff);
    send_double(64'h36a0_0000_0000_0000);
    send_double(64'h380f_ffff_f000_0000);
    send_double(64'h3810_0000_0000_0000);
    send_double(64'h3ff0_0000_1000_0000);
    send_double(64'h3ff0_0000_3000_0000);
    send_double(64'hffef_ffff_ffff_ffff);
    wait_drained();
  endtask

  task automatic test_random_values(input int count);
    logic [10:0] e;
    bit s;
    for (int i = 0; i < count; i++) begin
      s = 1'($urandom_range(1, 0));
      case ($urandom_range(9, 0))
        0: e = 11'($urandom_range(2047, 0));
        1: e = $urandom_range(1, 0) ? 11'h7ff : 11'h000;
        2: e = 11'(1023 + $urandom_range(129, 120));
        3: e = 11'(1023 - $urandom_range(152, 120));
        default: e = 11'(1023 - 126 + $urandom_range(253, 0));
      endcase
      if ($urandom_range(4, 0) == 0)
        send_double(make_double(s, e, {rand_frac() >> 29 << 29}
                                | (52'd1 << $urandom_range(51, 0))));
      else
        send_double(make_double(s, e, rand_frac()));
    end
  endtask

  task automatic test_output_backpressure();
    fork
      begin
        hold_off = 1;
        repeat (60) @(posedge clk);
        hold_off = 0;
      end
      test_random_values(40);
    join
    wait_drained();
  endtask

  task automatic test_full_rate();
    no_idle = 1;
    test_random_values(80);
    no_idle = 0;
    wait_drained();
  endtask

  // Receiver side: random stalls, checks each beat against the oldest prediction.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (single_q.size() == 0) report_mismatch("unexpected beat", out_ch.data, '0);
        else begin
          if (out_ch.data !== single_q[0])
            report_mismatch("single_bits", out_ch.data, single_q[0]);
          void'(single_q.pop_front());
        end
      end
      out_ch.ready <= !hold_off && (no_idle || $urandom_range(99, 0) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT && !done) begin
      $display("double_to_single_float_convert test failed");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_special_values();
    test_output_backpressure();
    test_full_rate();
    test_random_values(310);
    wait_drained();
    repeat (PIPE_STAGES + 4) @(posedge clk);
    done = 1;
    if (errors == 0 && single_q.size() == 0)
      $display("double_to_single_float_convert test passed");
    else
      $display("double_to_single_float_convert test failed");
    $finish;
  end
endmodule
